@@ rtl/sorted_priority_queue_macros.svh @@
// assertion helpers for the rtl
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/spq_pkg.sv @@
package spq_pkg;

   localparam int ITEM_W   = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ITEM_W-1:0] item;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ITEM_W-1:0]   front_item;
      logic [COUNT_W-1:0]  count;
      logic                is_empty;
      logic                is_full;
   } rsp_type;

   // broadcast to every cell in the row
   typedef struct packed {
      logic              enq;
      logic              deq;
      logic [ITEM_W-1:0] item;
   } cell_ctrl_type;

endpackage

@@ rtl/spq_cell.sv @@
module spq_cell
   import spq_pkg::*;
(
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic                occupied,
   input  logic                left_keep,
   input  logic [ITEM_W-1:0]   left_entry,
   input  logic [ITEM_W-1:0]   right_entry,
   output logic                keep,
   output logic [ITEM_W-1:0]   entry
);

   logic [ITEM_W-1:0] entry_ff;
   logic [ITEM_W-1:0] entry_in;

   // an entry not smaller than the new item stays where it is
   assign keep  = occupied && !(ctrl.item > entry_ff);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.enq) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in = ctrl.item;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctrl.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ rtl/sorted_priority_queue.sv @@
// channel   | ports                         | direction | handshake
// ----------+-------------------------------+-----------+---------------------------
// request   | start, busy, req_data         | in        | start && !busy
// response  | rsp_valid, rsp_data           | out       | rsp_valid for one cycle
//
// each request is latched on acceptance, the cell row
// compares and shifts in the next cycle, and the response is registered
// a new request may be accepted in the cycle its predecessor's response shows
// reset clears the pending flag, the response strobe and the entry count;
// cell contents are not reset, occupancy follows from the count
// the receiver cannot stall: every response is shown for exactly one cycle
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   // request latch
   logic    pend_ff;
   logic    pend_in;
   req_type req_ff;
   req_type req_in;

   // stored entry count, cell i is occupied when i < count
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // response register
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic          accept;
   logic          is_enq;
   logic          is_read;
   logic          q_full;
   logic          q_empty;
   cell_ctrl_type ctrl;
   logic [31:0]   count_wide;

   logic              occ   [DEPTH];
   logic              keep  [DEPTH];
   logic [ITEM_W-1:0] entry [DEPTH];

   assign accept  = start && !pend_ff;
   assign busy    = pend_ff;
   assign is_enq  = (req_ff.cmd == CMD_ENQUEUE);
   assign is_read = (req_ff.cmd == CMD_DEQUEUE) || (req_ff.cmd == CMD_PEEK);
   assign q_full  = (count_ff == FULL_CNT);
   assign q_empty = (count_ff == '0);

   // the row only moves in the cycle a request is pending
   assign ctrl.enq  = pend_ff && is_enq && !q_full;
   assign ctrl.deq  = pend_ff && (req_ff.cmd == CMD_DEQUEUE) && !q_empty;
   assign ctrl.item = req_ff.item;

   // row of cells, front of the queue in cell 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic              l_keep;
      logic [ITEM_W-1:0] l_entry;
      logic [ITEM_W-1:0] r_entry;

      assign occ[i] = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_first
         // nothing ahead of the front: an item that is not held back lands here
         assign l_keep  = 1'b1;
         assign l_entry = ctrl.item;
      end else begin : g_mid
         assign l_keep  = keep[i-1];
         assign l_entry = entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign r_entry = '0;
      end else begin : g_body
         assign r_entry = entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occ[i]),
         .left_keep   (l_keep),
         .left_entry  (l_entry),
         .right_entry (r_entry),
         .keep        (keep[i]),
         .entry       (entry[i])
      );
   end

   always_comb begin
      pend_in = pend_ff;
      req_in  = req_ff;
      if (accept) begin
         pend_in = 1'b1;
         req_in  = req_data;
      end else if (pend_ff) begin
         pend_in = 1'b0;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.enq) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.deq) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign count_wide = 32'(count_in);

   // response built from the state before the move and the count after it
   always_comb begin
      rsp_valid_in      = pend_ff;
      rsp_in.status     = STATUS_OK;
      rsp_in.front_item = '0;
      if (is_enq && q_full) begin
         rsp_in.status = STATUS_OVERFLOW;
      end else if (is_read && q_empty) begin
         rsp_in.status = STATUS_UNDERFLOW;
      end else if (is_read) begin
         rsp_in.front_item = entry[0];
      end
      rsp_in.count    = count_wide[COUNT_W-1:0];
      rsp_in.is_empty = (count_in == '0);
      rsp_in.is_full  = (count_in == FULL_CNT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (pend_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "sorted_priority_queue_macros.svh"

   // a pending request is answered in the next cycle, which also frees the port
   `SPQ_ASSERT_NEXT(a_pend_answers, clock, reset, pend_ff, rsp_valid && !busy, "pending request not answered")
   // acceptance always raises busy
   `SPQ_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy && !rsp_valid, "accept did not raise busy")
   // the count never exceeds the row length
   `SPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_CNT, "entry count out of range")
   // underflow only ever reports an empty queue
   `SPQ_ASSERT_NOW(a_underflow_empty, clock, reset, rsp_valid && (rsp_data.status == STATUS_UNDERFLOW), rsp_data.is_empty && (rsp_data.front_item == '0), "underflow on non-empty queue")

endmodule

@@ bench/tb_sorted_priority_queue.sv @@
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int QUEUE_DEPTH  = 16;
   localparam int RANDOM_COUNT = 1400;
   // the last stretch of random requests runs with no sender gaps
   localparam int BURST_TAIL   = 200;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 8;

   // the fourth command code has no meaning: the block must leave its state alone
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   // command mixes for the random segments, in percent
   localparam int FILL_ENQ    = 75;
   localparam int FILL_DEQ    = 15;
   localparam int DRAIN_ENQ   = 15;
   localparam int DRAIN_DEQ   = 70;
   localparam int MIXED_ENQ   = 45;
   localparam int MIXED_DEQ   = 40;
   localparam int RESERVED_PCT = 2;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   sorted_priority_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // shadow of the queue contents plus the responses still owed by the block
   class priority_order_checker;
      logic [ITEM_W-1:0] shadow_entries[$];
      rsp_type           pending_outcomes[$];
      int                fail_count;
      int                answered;

      task report_mismatch(input string field, input logic [63:0] got,
                           input logic [63:0] want);
         fail_count++;
         $display("mismatch %0d at %0t: %s got %0h expected %0h",
                  fail_count, $realtime, field, got, want);
      endtask

      // largest entry at the front; a new item goes behind every entry not smaller
      function rsp_type predict_outcome(input req_type r);
         rsp_type o;
         int      slot;
         o = '0;
         o.status = STATUS_OK;
         case (r.cmd)
            CMD_ENQUEUE: begin
               if (shadow_entries.size() >= QUEUE_DEPTH) begin
                  o.status = STATUS_OVERFLOW;
               end else begin
                  slot = shadow_entries.size();
                  while (slot > 0 && r.item > shadow_entries[slot-1]) slot--;
                  shadow_entries.insert(slot, r.item);
               end
            end
            CMD_DEQUEUE, CMD_PEEK: begin
               if (shadow_entries.size() == 0) begin
                  o.status = STATUS_UNDERFLOW;
               end else begin
                  o.front_item = shadow_entries[0];
                  if (r.cmd == CMD_DEQUEUE) void'(shadow_entries.pop_front());
               end
            end
            default: ;
         endcase
         o.count    = COUNT_W'(shadow_entries.size());
         o.is_empty = (shadow_entries.size() == 0);
         o.is_full  = (shadow_entries.size() >= QUEUE_DEPTH);
         return o;
      endfunction

      function void note_request(input req_type r);
         pending_outcomes.push_back(predict_outcome(r));
      endfunction

      task check_response(input rsp_type r);
         rsp_type w;
         answered++;
         if (pending_outcomes.size() == 0) begin
            report_mismatch("response with no request waiting", 64'(r), '0);
         end else begin
            w = pending_outcomes.pop_front();
            if (r.status !== w.status)
               report_mismatch("status", 64'(r.status), 64'(w.status));
            if (r.front_item !== w.front_item)
               report_mismatch("front_item", 64'(r.front_item), 64'(w.front_item));
            if (r.count !== w.count)
               report_mismatch("count", 64'(r.count), 64'(w.count));
            if (r.is_empty !== w.is_empty)
               report_mismatch("is_empty", 64'(r.is_empty), 64'(w.is_empty));
            if (r.is_full !== w.is_full)
               report_mismatch("is_full", 64'(r.is_full), 64'(w.is_full));
         end
      endtask
   endclass

   priority_order_checker chk;
   int issued;
   int stall_cycles;

   // clock
   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   // sample both channels at the edge; the response is checked before a
   // request taken at the same edge is noted, since it belongs to the older one
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) chk.check_response(rsp_data);
         if (start && !busy) chk.note_request(req_data);
      end
   end

   // watchdog: too long with neither a request taken nor a response shown
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_sorted_priority_queue: FAIL");
            $finish;
         end
      end
   end

   // values that favor ties and the ends of the range, with plenty of full words
   function automatic logic [ITEM_W-1:0] pick_item();
      int sel;
      sel = $urandom_range(9);
      if (sel < 4) return ITEM_W'($urandom_range(3));
      if (sel < 8) return ITEM_W'($urandom);
      if (sel == 8) return $urandom_range(1) ? '1 : '0;
      return ITEM_W'(1) << $urandom_range(ITEM_W - 1);
   endfunction

   function automatic req_type make_request(input int enq_pct, input int deq_pct);
      req_type r;
      int      roll;
      r.item = pick_item();
      roll = $urandom_range(99);
      if (roll < RESERVED_PCT)                    r.cmd = CMD_RESERVED;
      else if (roll < RESERVED_PCT + enq_pct)     r.cmd = CMD_ENQUEUE;
      else if (roll < RESERVED_PCT + enq_pct + deq_pct) r.cmd = CMD_DEQUEUE;
      else                                        r.cmd = CMD_PEEK;
      return r;
   endfunction

   function automatic int pick_gap(input int idle_pct);
      if (int'($urandom_range(99)) < idle_pct) return $urandom_range(1, 7);
      return 0;
   endfunction

   // hold start until the block takes the request; start stays high when
   // the next request follows with no gap
   task automatic issue(input logic [CMD_W-1:0] cmd, input logic [ITEM_W-1:0] item,
                        input int gap);
      req_type r;
      r.cmd  = cmd;
      r.item = item;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      issued++;
      if (gap > 0) begin
         // garbage on the data lines while start is low
         start    <= 1'b0;
         req_data <= {CMD_W'($urandom), ITEM_W'($urandom)};
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending until every response owed has come back
   task automatic await_all_answered();
      start <= 1'b0;
      while (chk.answered < issued) @(posedge clock);
   endtask

   initial begin
      req_type r;
      int      seg_left;
      int      enq_pct;
      int      deq_pct;
      int      idle_pct;
      int      mode;
      chk = new;
      issued = 0;
      stall_cycles = 0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue: both reads underflow, the reserved code does nothing
      issue(CMD_DEQUEUE, ITEM_W'($urandom), 0);
      issue(CMD_PEEK, '0, 2);
      issue(CMD_RESERVED, '1, 0);

      // first entry lands in an empty queue, then extremes and a tie
      issue(CMD_ENQUEUE, '0, 0);
      issue(CMD_ENQUEUE, '1, 1);
      issue(CMD_ENQUEUE, ITEM_W'(5), 0);
      issue(CMD_ENQUEUE, ITEM_W'(5), 0);
      issue(CMD_ENQUEUE, 32'h8000_0000, 3);
      issue(CMD_PEEK, '0, 0);

      // fill to the top
      repeat (QUEUE_DEPTH - 5) issue(CMD_ENQUEUE, pick_item(), pick_gap(30));

      // full queue: overflow, reserved code, peek and one removal
      issue(CMD_ENQUEUE, '1, 0);
      issue(CMD_RESERVED, '0, 0);
      issue(CMD_PEEK, '0, 0);
      issue(CMD_DEQUEUE, '0, 0);
      await_all_answered();

      // random part in segments that lean toward filling, draining or neither
      seg_left = 0;
      enq_pct  = MIXED_ENQ;
      deq_pct  = MIXED_DEQ;
      idle_pct = 0;
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(10, 60);
            mode = $urandom_range(2);
            case (mode)
               0: begin enq_pct = FILL_ENQ;  deq_pct = FILL_DEQ;  end
               1: begin enq_pct = DRAIN_ENQ; deq_pct = DRAIN_DEQ; end
               default: begin enq_pct = MIXED_ENQ; deq_pct = MIXED_DEQ; end
            endcase
            case ($urandom_range(2))
               0: idle_pct = 0;
               1: idle_pct = 15;
               default: idle_pct = 40;
            endcase
         end
         seg_left--;
         if (n >= RANDOM_COUNT - BURST_TAIL) idle_pct = 0;
         r = make_request(enq_pct, deq_pct);
         issue(r.cmd, r.item, pick_gap(idle_pct));
         if (n == RANDOM_COUNT / 2) await_all_answered();
      end

      await_all_answered();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (chk.pending_outcomes.size() != 0)
         chk.report_mismatch("requests left unanswered",
                             64'(chk.pending_outcomes.size()), '0);

      if (chk.fail_count == 0) begin
         $display("tb_sorted_priority_queue: PASS");
      end else begin
         $display("tb_sorted_priority_queue: FAIL");
      end
      $finish;
   end

endmodule
